// ===== rtl/core/rtcsp_pkg.sv =====
// Shared types, codes and helpers for the three-wire serial RTC port.
// No dependencies; used by every RTL file of the block.
package rtcsp_pkg;

  // Phase codes of the port state machine.
  localparam logic [2:0] PH_READY = 3'd0;
  localparam logic [2:0] PH_CMD1  = 3'd1;
  localparam logic [2:0] PH_CMD2  = 3'd2;
  localparam logic [2:0] PH_READ  = 3'd3;
  localparam logic [2:0] PH_WRITE = 3'd4;

  // Register select codes carried in the command byte.
  localparam logic [2:0] REG_DATETIME = 3'd2;
  localparam logic [2:0] REG_STATUS2  = 3'd4;

  // Port access kinds.
  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  // High nibble that marks a command byte sent in reversed bit order.
  localparam logic [3:0] CMD_FLIP_NIBBLE = 4'd6;

  localparam int unsigned CMD_BITS  = 8;
  localparam int unsigned WORD_BITS = 56;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 8;
  localparam logic [7:0] YEAR_BASE = 8'd100;

  // Current time sample handed to the date/time word builder.
  typedef struct packed {
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [2:0] weekday;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } rtcsp_time_t;

  // Two-digit BCD of a value saturated at 99. The tens digit comes from a
  // reciprocal multiply (205/2048), exact for every value up to 99.
  function automatic logic [7:0] bcd8(input logic [7:0] v);
    logic [6:0]  sat;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  rem;
    sat  = (v > 8'd99) ? 7'd99 : v[6:0];
    prod = 15'(sat) * 15'd205;
    tens = prod[14:11];
    rem  = sat - 7'(7'(tens) * 7'd10);
    return {tens, rem[3:0]};
  endfunction

  // Full bit reversal of a command byte.
  function automatic logic [7:0] flip8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7 - i];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/rtc_serial_port_fsm_unit.sv =====
// Top level of the three-wire serial RTC port: input register, port state
// machine and result register. Depends on rtcsp_pkg and rtcsp_datetime.
//
//  Channel | Dir | tdata (low bit up)                               | tuser
//  --------+-----+--------------------------------------------------+-------------
//  in_     | in  | pin_value, write_mask, now_seconds, now_minutes,  | cmd
//          |     | now_hours, now_weekday, now_day, now_month,       |
//          |     | now_year, 3 zero bits                             |
//  out_    | out | port_read, 4 zero bits                            | error
//
// Every beat is one port access and yields one result beat. The access sits in
// the input register and is then resolved into the result register, from which
// the result is taken. One beat per cycle while the result side is not stalled:
// the state machine only needs the state left by the last access.
// in_tready drops only while a result waits and the input register is full.
// Reset (synchronous, active low) returns to READY with cleared shifts and latch.
module rtc_serial_port_fsm_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // pin_value[3:0], write_mask[7:4], now_seconds[13:8], now_minutes[19:14],
  // now_hours[24:20], now_weekday[27:25], now_day[32:28], now_month[36:33],
  // now_year[44:37], zero pad [47:45]
  input  logic [rtcsp_pkg::IN_DATA_W-1:0]    in_tdata,
  // cmd[0]
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // port_read[3:0], zero pad [7:4]
  output logic [rtcsp_pkg::OUT_DATA_W-1:0]   out_tdata,
  // error[0]
  output logic                               out_tuser
);

  // Input register.
  logic                      in_valid_r;
  logic                      in_cmd_r;
  logic [3:0]                in_pins_r;
  logic [3:0]                in_mask_r;
  rtcsp_pkg::rtcsp_time_t    in_time_r;

  // Port state.
  logic [2:0]                phase_r, phase_nxt;
  logic [7:0]                cmd_shift_r, cmd_shift_nxt;
  logic [3:0]                bit_cnt_r, bit_cnt_nxt;
  logic [rtcsp_pkg::WORD_BITS-1:0] rd_shift_r, rd_shift_nxt;
  logic [3:0]                latch_r, latch_nxt;

  // Result register.
  logic                      out_valid_r;
  logic [3:0]                out_port_r;
  logic                      out_err_r;

  logic                      advance;
  logic                      fire;
  logic                      err;
  logic                      sck, sio, cs;
  logic [3:0]                latch_mid;
  logic [7:0]                cmd_ins;
  logic [7:0]                cmd_dec;
  logic [3:0]                cnt_inc;
  logic [rtcsp_pkg::WORD_BITS-1:0] dt_word;

  // The stage moves whenever the result register is free or being emptied.
  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  assign sck = in_pins_r[0];
  assign sio = in_pins_r[1];
  assign cs  = in_pins_r[2];

  rtcsp_datetime u_datetime (
    .now  (in_time_r),
    .word (dt_word)
  );

  always_comb begin
    phase_nxt     = phase_r;
    cmd_shift_nxt = cmd_shift_r;
    bit_cnt_nxt   = bit_cnt_r;
    rd_shift_nxt  = rd_shift_r;
    latch_mid     = latch_r;
    err           = 1'b0;

    // Incoming SIO bit placed at the current command bit position.
    cmd_ins = cmd_shift_r;
    cmd_ins[bit_cnt_r[2:0]] = sio;
    cnt_inc = bit_cnt_r + 4'd1;
    // A command byte with the flip marker in its high nibble arrived reversed.
    cmd_dec = (cmd_ins[7:4] == rtcsp_pkg::CMD_FLIP_NIBBLE) ? rtcsp_pkg::flip8(cmd_ins)
                                                           : cmd_ins;

    if (in_cmd_r == rtcsp_pkg::ACC_WRITE) begin
      case (phase_r)
        rtcsp_pkg::PH_READY: begin
          // Start condition: chip select low with the clock high.
          if (!cs && sck) begin
            cmd_shift_nxt = 8'd0;
            bit_cnt_nxt   = 4'd0;
            phase_nxt     = rtcsp_pkg::PH_CMD1;
          end else begin
            err = 1'b1;
          end
        end
        rtcsp_pkg::PH_CMD1: begin
          if (cs && sck) begin
            phase_nxt = rtcsp_pkg::PH_CMD2;
          end else begin
            err = 1'b1;
          end
        end
        rtcsp_pkg::PH_CMD2: begin
          if (!cs) begin
            err = 1'b1;
          end else if (!sck) begin
            cmd_shift_nxt = cmd_ins;
          end else if (cnt_inc != 4'(rtcsp_pkg::CMD_BITS)) begin
            cmd_shift_nxt = cmd_ins;
            bit_cnt_nxt   = cnt_inc;
          end else begin
            // Last command bit: decode the register select. An unknown
            // register leaves the phase, shifts and bit count untouched.
            if (cmd_dec[6:4] == rtcsp_pkg::REG_DATETIME) begin
              rd_shift_nxt = dt_word;
            end else if (cmd_dec[6:4] == rtcsp_pkg::REG_STATUS2) begin
              rd_shift_nxt = '0;
            end else begin
              err = 1'b1;
            end
            if (!err) begin
              cmd_shift_nxt = cmd_dec;
              bit_cnt_nxt   = 4'(rtcsp_pkg::CMD_BITS);
              phase_nxt     = cmd_dec[7] ? rtcsp_pkg::PH_READ : rtcsp_pkg::PH_WRITE;
            end
          end
        end
        rtcsp_pkg::PH_READ: begin
          // Data goes out on a rising SCK: only when the latched clock was low.
          if (cs && sck) begin
            if (!latch_r[0]) begin
              latch_mid[1] = rd_shift_r[0];
              rd_shift_nxt = rd_shift_r >> 1;
            end
          end else if (!cs) begin
            phase_nxt = rtcsp_pkg::PH_READY;
          end
        end
        default: begin
          // The write phase and unused codes reject every pin write.
          err = 1'b1;
        end
      endcase
      // The pins are latched on every write, error or not.
      latch_nxt = (latch_mid & ~in_mask_r) | in_pins_r;
    end else begin
      latch_nxt = latch_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_cmd_r  <= in_tuser;
      in_pins_r <= in_tdata[3:0];
      in_mask_r <= in_tdata[7:4];
      in_time_r <= '{year:    in_tdata[44:37],
                     month:   in_tdata[36:33],
                     day:     in_tdata[32:28],
                     weekday: in_tdata[27:25],
                     hours:   in_tdata[24:20],
                     minutes: in_tdata[19:14],
                     seconds: in_tdata[13:8]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= rtcsp_pkg::PH_READY;
      cmd_shift_r <= 8'd0;
      bit_cnt_r   <= 4'd0;
      rd_shift_r  <= '0;
      latch_r     <= 4'd0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      cmd_shift_r <= cmd_shift_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      rd_shift_r  <= rd_shift_nxt;
      latch_r     <= latch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_port_r <= latch_nxt;
      out_err_r  <= err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_port_r};
  assign out_tuser  = out_err_r;

endmodule

// ===== rtl/core/rtcsp_datetime.sv =====
// Builds the 56-bit BCD date/time word from a binary time sample.
// Depends on rtcsp_pkg (time struct, BCD helper).
module rtcsp_datetime (
  input  rtcsp_pkg::rtcsp_time_t                  now,
  output logic [rtcsp_pkg::WORD_BITS-1:0]         word
);

  logic [4:0] month_one;
  logic [7:0] year_off;

  // Month is sent from one; the year is sent as years past the century base.
  assign month_one = 5'(now.month) + 5'd1;
  assign year_off  = (now.year < rtcsp_pkg::YEAR_BASE) ? 8'd0
                                                       : now.year - rtcsp_pkg::YEAR_BASE;

  // Seconds in the top byte, year in the bottom byte so it shifts out first.
  assign word = {rtcsp_pkg::bcd8(8'(now.seconds)),
                 rtcsp_pkg::bcd8(8'(now.minutes)),
                 rtcsp_pkg::bcd8(8'(now.hours)),
                 rtcsp_pkg::bcd8(8'(now.weekday)),
                 rtcsp_pkg::bcd8(8'(now.day)),
                 rtcsp_pkg::bcd8(8'(month_one)),
                 rtcsp_pkg::bcd8(year_off)};

endmodule

// ===== rtl/core/rtcsp_checker.sv =====
// Port-level checker for the serial RTC port, bound to the top level.
// Depends on rtcsp_pkg for the bus widths.
module rtcsp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [rtcsp_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                             out_tuser
);

  // A result waiting on the output holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Input back-pressure only ever comes from a stalled full result register.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output stall");

  // The pad above the port bits is always zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:4] == 4'd0)
    else $error("nonzero pad bits in result");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // An accepted beat on an empty block yields a result through the input and result registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid && $past(!in_tvalid || !in_tready) |=> ##1 out_tvalid)
    else $error("result missing after accepted beat");

endmodule

bind rtc_serial_port_fsm_unit rtcsp_checker u_rtcsp_checker (.*);

// ===== sim/rtcsp_port_checker.sv =====
`timescale 1ns / 100ps
// Checker for the three-wire serial RTC port: watches both stream channels,
// predicts every result beat and compares it. Depends on rtcsp_pkg only.
module rtcsp_port_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [rtcsp_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [rtcsp_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                             out_tuser,
  output int unsigned                      mismatch_count,
  output int unsigned                      pending_count
);
  import rtcsp_pkg::*;

  typedef struct packed {
    logic [3:0] port_read;
    logic       error;
  } port_result_t;

  port_result_t expected_port_q[$];
  port_result_t fresh;
  port_result_t oldest;
  int unsigned  mismatches = 0;

  // Shadow of the port state machine.
  logic [2:0]  phase;
  logic [7:0]  cmd_shift;
  logic [3:0]  bit_cnt;
  logic [55:0] time_word_sr;
  logic [3:0]  latch;

  function automatic logic [7:0] to_bcd(input int unsigned v);
    if (v > 99) v = 99;
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  function automatic logic [7:0] mirror_byte(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = b[7 - i];
    return r;
  endfunction

  // Date/time word: seconds in the top byte, year offset in the bottom one.
  function automatic logic [55:0] build_time_word(input rtcsp_time_t t);
    int unsigned yrel;
    yrel = (t.year < YEAR_BASE) ? 0 : t.year - YEAR_BASE;
    return {to_bcd(t.seconds), to_bcd(t.minutes), to_bcd(t.hours), to_bcd(t.weekday),
            to_bcd(t.day), to_bcd(int'(t.month) + 1), to_bcd(yrel)};
  endfunction

  task automatic predict_access(input logic acc, input logic [IN_DATA_W-1:0] d,
                                output port_result_t res);
    logic [3:0] pins;
    logic [3:0] mask;
    logic       sck;
    logic       sio;
    logic       cs;
    logic       err;
    logic [2:0] pos;
    logic [7:0] sh;
    logic [3:0] nib;
    pins = d[3:0];
    mask = d[7:4];
    sck  = pins[0];
    sio  = pins[1];
    cs   = pins[2];
    err  = 1'b0;
    if (acc == ACC_WRITE) begin
      case (phase)
        PH_READY: begin
          if (!cs && sck) begin
            cmd_shift = '0;
            bit_cnt   = '0;
            phase     = PH_CMD1;
          end else begin
            err = 1'b1;
          end
        end
        PH_CMD1: begin
          if (cs && sck) phase = PH_CMD2;
          else err = 1'b1;
        end
        PH_CMD2: begin
          if (cs) begin
            pos = bit_cnt[2:0];
            sh = cmd_shift;
            sh[pos] = sio;
            if (!sck) begin
              cmd_shift = sh;
            end else if (bit_cnt + 4'd1 != 4'd8) begin
              cmd_shift = sh;
              bit_cnt   = bit_cnt + 4'd1;
            end else begin
              if (sh[7:4] == CMD_FLIP_NIBBLE) sh = mirror_byte(sh);
              nib = sh[7:4];
              if (nib[2:0] == REG_DATETIME) time_word_sr = build_time_word(d[44:8]);
              else if (nib[2:0] == REG_STATUS2) time_word_sr = '0;
              else err = 1'b1;
              if (!err) begin
                cmd_shift = sh;
                bit_cnt   = 4'd8;
                phase     = nib[3] ? PH_READ : PH_WRITE;
              end
            end
          end else begin
            err = 1'b1;
          end
        end
        PH_READ: begin
          if (cs && sck) begin
            // Only a rising SCK, judged by the latched SCK bit, shifts a bit out.
            if (!latch[0]) begin
              latch[1]     = time_word_sr[0];
              time_word_sr = time_word_sr >> 1;
            end
          end else if (!cs) begin
            phase = PH_READY;
          end
        end
        default: err = 1'b1;
      endcase
      latch = (latch & ~mask) | pins;
    end
    res.port_read = latch;
    res.error     = err;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase        = PH_READY;
      cmd_shift    = '0;
      bit_cnt      = '0;
      time_word_sr = '0;
      latch        = '0;
      expected_port_q.delete();
    end else begin
      // Retire first so a stray result cannot pair with this cycle's input.
      if (out_tvalid && out_tready) begin
        if (expected_port_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat, expected none, actual tdata=%h tuser=%b",
                   $time, out_tdata, out_tuser);
        end else begin
          oldest = expected_port_q.pop_front();
          if (out_tdata !== OUT_DATA_W'(oldest.port_read) || out_tuser !== oldest.error) begin
            mismatches++;
            $display("%0t: result mismatch, expected tdata=%h tuser=%b, actual tdata=%h tuser=%b",
                     $time, OUT_DATA_W'(oldest.port_read), oldest.error, out_tdata, out_tuser);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_access(in_tuser, in_tdata, fresh);
        expected_port_q.push_back(fresh);
      end
    end
    mismatch_count <= mismatches;
    pending_count  <= expected_port_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the three-wire serial RTC port: clock, reset, stimulus and
// verdict. Depends on rtcsp_pkg, rtc_serial_port_fsm_unit and rtcsp_port_checker.
module tb_top;
  import rtcsp_pkg::*;

  localparam int unsigned RANDOM_BEATS = 1200;
  localparam int unsigned STALL_LIMIT  = 2000;

  // Pin bits inside pin_value and write_mask.
  localparam logic [3:0] PIN_SCK   = 4'b0001;
  localparam logic [3:0] PIN_SIO   = 4'b0010;
  localparam logic [3:0] PIN_CS    = 4'b0100;
  localparam logic [3:0] PIN_SPARE = 4'b1000;

  // Command nibbles: bit 3 picks a read, bits 2..0 the register.
  localparam logic [3:0] CMD_READ_TIME  = {1'b1, REG_DATETIME};
  localparam logic [3:0] CMD_READ_STAT  = {1'b1, REG_STATUS2};
  localparam logic [3:0] CMD_WRITE_TIME = {1'b0, REG_DATETIME};

  typedef enum int {
    TIME_RANDOM    = 0,
    TIME_ONES      = 1,
    TIME_ZEROS     = 2,
    TIME_RANGE_TOP = 3,
    TIME_RANGE_LOW = 4
  } time_mode_e;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  int unsigned mismatch_total;
  int unsigned results_owed;
  int unsigned beats_sent = 0;
  time_mode_e  time_hold  = TIME_RANDOM;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rtc_serial_port_fsm_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  rtcsp_port_checker watch (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .mismatch_count(mismatch_total),
    .pending_count (results_owed)
  );

  // Pause lengths: mostly short, now and then a long one.
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [3:0] spare_bit();
    return $urandom_range(0, 1) ? PIN_SPARE : 4'b0000;
  endfunction

  function automatic logic [3:0] sio_bit();
    return $urandom_range(0, 1) ? PIN_SIO : 4'b0000;
  endfunction

  function automatic logic [3:0] any_mask();
    return $urandom_range(0, 1) ? 4'hF : 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [3:0] nibble_mirror(input logic [3:0] n);
    return {n[0], n[1], n[2], n[3]};
  endfunction

  // The sink side stalls at random. In every fourth stretch of the cycle count it
  // starts no new stall, so back-to-back traffic gets exercised too.
  longint unsigned cycle_no  = 0;
  int unsigned     hold_left = 0;
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else begin
      out_tready <= 1'b1;
      if ((cycle_no / 512) % 4 != 3 && $urandom_range(0, 3) == 0) hold_left <= pick_pause();
    end
  end

  // Watchdog: any stretch without a single accepted beat on either channel
  // longer than the limit means the block is stuck.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // One port access as one input beat. The current-time fields ride along on
  // every beat; the block only looks at them on the beat that completes a
  // date/time command. An optional idle gap comes first, except in calm
  // stretches of 128 beats.
  task automatic push_beat(input logic acc, input logic [3:0] pins, input logic [3:0] mask);
    int unsigned gap;
    time_mode_e  m;
    rtcsp_time_t t;
    logic [63:0] raw;
    gap = 0;
    if ((beats_sent / 128) % 4 != 1 && $urandom_range(0, 99) >= 55) gap = pick_pause();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    m = time_hold;
    if (m == TIME_RANDOM && $urandom_range(0, 9) >= 7) m = time_mode_e'($urandom_range(1, 4));
    case (m)
      TIME_ONES:      t = '1;
      TIME_ZEROS:     t = '0;
      TIME_RANGE_TOP: t = '{year: 8'd199, month: 4'd11, day: 5'd31, weekday: 3'd6,
                            hours: 5'd23, minutes: 6'd59, seconds: 6'd59};
      TIME_RANGE_LOW: t = '{year: 8'd100, month: 4'd0, day: 5'd1, weekday: 3'd0,
                            hours: 5'd0, minutes: 6'd0, seconds: 6'd0};
      default: begin
        raw = {$urandom, $urandom};
        t = raw[36:0];
      end
    endcase
    in_tvalid <= 1'b1;
    in_tuser  <= acc;
    in_tdata  <= IN_DATA_W'({t, mask, pins});
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  // A pin write, sometimes preceded by a plain latch read. Reads never touch
  // the state machine, so they can be sprinkled anywhere in a transfer.
  task automatic pin_write(input logic [3:0] pins, input logic [3:0] mask);
    if ($urandom_range(0, 9) == 0)
      push_beat(ACC_READ, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    push_beat(ACC_WRITE, pins, mask);
  endtask

  // Stop sending until the checker holds no open expectation.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  // One complete transfer: start condition, the CS/SCK step into the command
  // phase, eight command bits, then read_bits SCK periods of data and a CS-low
  // exit. Noise beats are chosen so that they err or do nothing in the phase
  // they land in; the sequence therefore always stays in step with the block.
  // With retry_top set, the byte sent first names an unknown register (its
  // high nibble has the flip pattern plus bit 7); resending bit 7 as zero then
  // turns it into a bit-reversed command the block accepts.
  task automatic run_transfer(input logic [7:0] cmd_byte, input logic retry_top,
                              input int unsigned read_bits);
    logic [3:0]  p;
    int unsigned k;
    repeat ($urandom_range(0, 2)) begin
      do p = 4'($urandom_range(0, 15)); while ((p & (PIN_CS | PIN_SCK)) == PIN_SCK);
      pin_write(p, any_mask());
    end
    pin_write(PIN_SCK | sio_bit() | spare_bit(), any_mask());

    repeat ($urandom_range(0, 2)) begin
      do p = 4'($urandom_range(0, 15)); while ((p & (PIN_CS | PIN_SCK)) == (PIN_CS | PIN_SCK));
      pin_write(p, any_mask());
    end
    pin_write(PIN_CS | PIN_SCK | sio_bit() | spare_bit(), any_mask());

    for (k = 0; k < 8; k++) begin
      // SCK low with CS high only previews the bit without advancing.
      if ($urandom_range(0, 3) == 0) pin_write(PIN_CS | sio_bit() | spare_bit(), any_mask());
      if ($urandom_range(0, 7) == 0) pin_write(4'($urandom_range(0, 15)) & ~PIN_CS, any_mask());
      pin_write(PIN_CS | PIN_SCK | (cmd_byte[k] ? PIN_SIO : 4'b0000) | spare_bit(), any_mask());
    end
    if (retry_top) pin_write(PIN_CS | PIN_SCK | spare_bit(), any_mask());

    // Data phase. Most beats clear the latched SCK on the low half and leave
    // the latched SIO alone on the high half, so the shifted bit shows up.
    for (k = 0; k < read_bits; k++) begin
      if ($urandom_range(0, 4) != 0)
        pin_write(PIN_CS | sio_bit() | spare_bit(), (4'($urandom_range(0, 15)) & 4'b1101) | PIN_SCK);
      else
        pin_write(PIN_CS | sio_bit() | spare_bit(), 4'($urandom_range(0, 15)));
      if ($urandom_range(0, 4) != 0)
        pin_write(PIN_CS | PIN_SCK | spare_bit(), (4'($urandom_range(0, 15)) & 4'b1101) | PIN_SCK);
      else
        pin_write(PIN_CS | PIN_SCK | sio_bit() | spare_bit(), 4'($urandom_range(0, 15)));
    end
    pin_write(4'($urandom_range(0, 15)) & ~PIN_CS, any_mask());
  endtask

  initial begin : stimulus
    logic [7:0]  cmd_byte;
    logic [3:0]  target;
    logic        retry;
    int unsigned r;
    int unsigned bits;
    int unsigned transfers;
    int unsigned k;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening. Latch reads and pin extremes with the machine idle:
    // CS high and SCK low both leave it in READY and raise the error flag.
    push_beat(ACC_READ, 4'h0, 4'h0);
    push_beat(ACC_WRITE, 4'hF, 4'h0);
    push_beat(ACC_WRITE, 4'h0, 4'hF);
    push_beat(ACC_READ, 4'hF, 4'hF);
    // Start condition, then a wrong CS/SCK combination in the first command
    // step, then the right one.
    push_beat(ACC_WRITE, PIN_SCK | PIN_SIO | PIN_SPARE, 4'hF);
    push_beat(ACC_WRITE, PIN_SCK, 4'hF);
    push_beat(ACC_WRITE, PIN_CS | PIN_SCK, 4'hF);
    // CS low while shifting the command is refused.
    push_beat(ACC_WRITE, PIN_SCK | PIN_SIO, 4'hF);
    // The first eight bits name register six, which is unknown. Resending the
    // top bit as zero gives a byte in reversed order that reads the date and
    // time; the time fields are all ones, so the year offset saturates at 99.
    cmd_byte = {CMD_FLIP_NIBBLE | 4'b1000, nibble_mirror(CMD_READ_TIME)};
    for (k = 0; k < 8; k++)
      push_beat(ACC_WRITE, PIN_CS | PIN_SCK | (cmd_byte[k] ? PIN_SIO : 4'b0000), 4'hF);
    time_hold = TIME_ONES;
    push_beat(ACC_WRITE, PIN_CS | PIN_SCK, 4'hF);
    time_hold = TIME_RANDOM;
    repeat (2) begin
      push_beat(ACC_WRITE, PIN_CS, PIN_CS | PIN_SCK);
      push_beat(ACC_WRITE, PIN_CS | PIN_SCK, PIN_CS | PIN_SCK);
    end
    push_beat(ACC_WRITE, 4'h0, 4'hF);
    wait_for_drain();

    // Random transfers with random content. The source also holds back until
    // the result stream has fully caught up after every fifth transfer.
    transfers = 0;
    while (beats_sent < RANDOM_BEATS) begin
      r      = $urandom_range(0, 99);
      target = $urandom_range(0, 1) ? CMD_READ_TIME : CMD_READ_STAT;
      retry  = 1'b0;
      if (r < 35) begin
        cmd_byte = {CMD_READ_TIME, 4'($urandom_range(0, 15))};
      end else if (r < 55) begin
        cmd_byte = {CMD_READ_STAT, 4'($urandom_range(0, 15))};
      end else if (r < 80) begin
        cmd_byte = {CMD_FLIP_NIBBLE, nibble_mirror(target)};
      end else begin
        cmd_byte = {CMD_FLIP_NIBBLE | 4'b1000, nibble_mirror(target)};
        retry    = 1'b1;
      end
      bits = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 16) : $urandom_range(56, 64);
      run_transfer(cmd_byte, retry, bits);
      transfers++;
      if (transfers % 5 == 0) wait_for_drain();
    end

    // A write command parks the machine in the write phase for good, since
    // only reset leaves it, so it comes last. Every write there must err.
    run_transfer({CMD_WRITE_TIME, 4'($urandom_range(0, 15))}, 1'b0, 0);
    repeat (6)
      push_beat(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));

    wait_for_drain();
    repeat (20) @(posedge clk);
    if (mismatch_total == 0 && results_owed == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
